[rtl/core/sefr_pkg.sv]
// Shared types, constants and helpers for the STX/ETX frame receiver.
package sefr_pkg;

    localparam int PAYLOAD_DEPTH = 256;
    localparam int ADDR_W        = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 24;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;

    localparam logic REQ_RX = 1'b0;
    localparam logic REQ_RD = 1'b1;

    localparam logic [2:0] PHC_START = 3'd0;
    localparam logic [2:0] PHC_LEN   = 3'd1;
    localparam logic [2:0] PHC_DATA  = 3'd2;
    localparam logic [2:0] PHC_SUM   = 3'd3;
    localparam logic [2:0] PHC_END   = 3'd4;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_DATA  = 5'b00100,
        PH_SUM   = 5'b01000,
        PH_END   = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_OK   = 2'd1,
        EV_SUM  = 2'd2,
        EV_END  = 2'd3
    } ev_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
        ev_t               ev;
        logic [7:0]        frame_length;
        logic [2:0]        phase_code;
    } cmd_t;

    function automatic logic [2:0] phase_code(input phase_t p);
        logic [2:0] c;
        unique case (p)
            PH_LEN:  c = PHC_LEN;
            PH_DATA: c = PHC_DATA;
            PH_SUM:  c = PHC_SUM;
            PH_END:  c = PHC_END;
            default: c = PHC_START;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/sefr_front.sv]
// Front end: accepts requests, steps the frame phase machine, issues commands.
module sefr_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sefr_pkg::S_TDATA_W-1:0]     s_tdata,  // data_byte[7:0], read_index[15:8]
    input  logic                               s_tuser,  // req_type[0]
    input  logic                               fifo_full,
    output logic                               push,
    output sefr_pkg::cmd_t                     cmd
);
    import sefr_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] expected_reg, expected_next;
    logic [7:0] acc_len_reg, acc_len_next;
    logic [7:0] b;
    logic [7:0] idx;
    ev_t        ev;
    logic       wr;

    assign b        = s_tdata[7:0];
    assign idx      = s_tdata[15:8];
    assign s_tready = ~fifo_full;
    assign push     = s_tvalid & s_tready;

    always_comb begin
        phase_next    = phase_reg;
        xor_next      = xor_reg;
        count_next    = count_reg;
        expected_next = expected_reg;
        acc_len_next  = acc_len_reg;
        ev            = EV_NONE;
        wr            = 1'b0;
        if (s_tuser == REQ_RX) begin
            unique case (phase_reg)
                PH_LEN: begin
                    expected_next = b;
                    phase_next    = (b != 8'd0) ? PH_DATA : PH_SUM;
                end
                PH_DATA: begin
                    wr         = ({1'b0, count_reg} < 9'(PAYLOAD_DEPTH));
                    xor_next   = xor_reg ^ b;
                    count_next = count_reg + 8'd1;
                    if (count_next == expected_reg) begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM: begin
                    if (b == xor_reg) begin
                        phase_next = PH_END;
                    end else begin
                        phase_next = PH_START;
                        ev         = EV_SUM;
                    end
                end
                PH_END: begin
                    if (b == END_BYTE) begin
                        acc_len_next = count_reg;
                        ev           = EV_OK;
                    end else begin
                        ev = EV_END;
                    end
                    phase_next = PH_START;
                end
                default: begin
                    if (b == START_BYTE) begin
                        count_next    = 8'd0;
                        expected_next = 8'd0;
                        xor_next      = 8'd0;
                        phase_next    = PH_LEN;
                    end else begin
                        phase_next = PH_START;
                    end
                end
            endcase
        end
    end

    always_comb begin
        cmd.wr_en        = wr;
        cmd.rd_en        = (s_tuser == REQ_RD) && (idx < acc_len_reg)
                           && ({1'b0, idx} < 9'(PAYLOAD_DEPTH));
        cmd.addr         = (s_tuser == REQ_RD) ? idx[ADDR_W-1:0] : count_reg[ADDR_W-1:0];
        cmd.wdata        = b;
        cmd.ev           = ev;
        cmd.frame_length = acc_len_next;
        cmd.phase_code   = phase_code(phase_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            xor_reg      <= 8'd0;
            count_reg    <= 8'd0;
            expected_reg <= 8'd0;
            acc_len_reg  <= 8'd0;
        end else if (push) begin
            phase_reg    <= phase_next;
            xor_reg      <= xor_next;
            count_reg    <= count_next;
            expected_reg <= expected_next;
            acc_len_reg  <= acc_len_next;
        end
    end

endmodule

[rtl/core/sefr_cmd_fifo.sv]
// Short command queue between the front end and the back end.
module sefr_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sefr_pkg::cmd_t cmd_in,
    input  logic           pop,
    output sefr_pkg::cmd_t cmd_out,
    output logic           full,
    output logic           empty
);
    import sefr_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg, count_next;

    assign full    = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/sefr_back.sv]
// Back end: payload memory access and the registered result stage.
module sefr_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cmd_avail,
    input  sefr_pkg::cmd_t                 cmd,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sefr_pkg::M_TDATA_W-1:0] m_tdata  // event_res[1:0], frame_length[9:2],
                                                    // read_data[17:10], phase_now[20:18]
);
    import sefr_pkg::*;

    logic [7:0] mem [PAYLOAD_DEPTH];
    logic       out_valid_reg;
    ev_t        ev_reg;
    logic [7:0] len_reg;
    logic [2:0] phc_reg;
    logic       rd_sel_reg;
    logic [7:0] rd_data_reg;
    logic [7:0] rd_out;

    assign pop      = cmd_avail && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign rd_out   = rd_sel_reg ? rd_data_reg : 8'd0;
    assign m_tdata  = {3'b000, phc_reg, rd_out, len_reg, ev_reg};

    always_ff @(posedge aclk) begin
        if (pop && cmd.wr_en) begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (pop && cmd.rd_en) begin
            rd_data_reg <= mem[cmd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ev_reg     <= cmd.ev;
            len_reg    <= cmd.frame_length;
            phc_reg    <= cmd.phase_code;
            rd_sel_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

[rtl/core/stx_etx_frame_receiver_core.sv]
// Top level of the STX/ETX frame receiver: front end, command queue, back end.
//
//  Channel  Dir  Data                                           Side band
//  s_       in   data_byte[7:0] read_index[15:8]                tuser: req_type
//  m_       out  event_res[1:0] frame_length[9:2]               -
//                read_data[17:10] phase_now[20:18]
//
//  One request per cycle sustained while the result side keeps the queue from filling;
//  a result passes through the command queue, then the registered result stage.
//  Reset (aresetn low, synchronous) clears phase, checksum, counts and queue;
//  payload memory contents stay undefined until written.
//  A stalled output fills the four-entry queue, then s_tready drops.
module stx_etx_frame_receiver_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sefr_pkg::S_TDATA_W-1:0] s_tdata,  // data_byte[7:0], read_index[15:8]
    input  logic                           s_tuser,  // req_type[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sefr_pkg::M_TDATA_W-1:0] m_tdata   // event_res[1:0], frame_length[9:2],
                                                     // read_data[17:10], phase_now[20:18]
);
    import sefr_pkg::*;

    cmd_t cmd_in, cmd_out;
    logic push, pop, full, empty;

    sefr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (full),
        .push      (push),
        .cmd       (cmd_in)
    );

    sefr_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .cmd_in  (cmd_in),
        .pop     (pop),
        .cmd_out (cmd_out),
        .full    (full),
        .empty   (empty)
    );

    sefr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_avail (~empty),
        .cmd       (cmd_out),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/core/sefr_checker.sv]
// Port-level checker for the frame receiver, bound to the top level.
module sefr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sefr_pkg::M_TDATA_W-1:0] m_tdata
);
    import sefr_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_after_reset: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("request side not ready after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[20:18] <= PHC_END))
        else $error("phase code out of range");

    a_event_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] != EV_NONE)) |-> (m_tdata[20:18] == PHC_START))
        else $error("frame event without return to start hunt");

endmodule

bind stx_etx_frame_receiver_core sefr_checker u_sefr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/testbench.sv]
// Self-checking stream testbench for the STX/ETX frame receiver with a request-order predictor.
`timescale 1ns / 1ps

module testbench;
    import sefr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } rx_req_t;

    typedef struct packed {
        ev_t        ev;
        logic [7:0] len;
        logic [7:0] rd;
        logic [2:0] ph;
    } frame_res_t;

    typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_END, FR_CUT} frame_fault_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    rx_req_t    pending_reqs[$];
    frame_res_t expected_res[$];

    int          send_idle_pct = 0;
    int          rcv_stall_pct = 0;
    bit          hold_go       = 1'b0;
    bit          hold_done     = 1'b0;
    int          hold_left     = 0;
    logic        req_taken     = 1'b0;
    int          stim_count    = 0;
    int          err_count     = 0;
    int          res_count     = 0;
    int          rx_reqs       = 0;
    int          rd_reqs       = 0;
    int          in_stalls     = 0;
    int          ev_tally[4]   = '{0, 0, 0, 0};
    int unsigned cycle_count   = 0;

    logic [2:0] rx_phase   = PHC_START;
    logic [7:0] rx_xor     = 8'h00;
    logic [7:0] rx_count   = 8'h00;
    logic [7:0] rx_expect  = 8'h00;
    logic [7:0] rx_acc_len = 8'h00;
    logic [7:0] rx_store[0:PAYLOAD_DEPTH-1];

    stx_etx_frame_receiver_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic frame_res_t frame_rx_predict(input rx_req_t r);
        frame_res_t res;
        res.ev = EV_NONE;
        res.rd = 8'h00;
        if (r.req_type == REQ_RX) begin
            case (rx_phase)
                PHC_LEN: begin
                    rx_expect = r.data_byte;
                    rx_phase  = (r.data_byte != 8'h00) ? PHC_DATA : PHC_SUM;
                end
                PHC_DATA: begin
                    rx_store[rx_count] = r.data_byte;
                    rx_xor   = rx_xor ^ r.data_byte;
                    rx_count = rx_count + 8'd1;
                    if (rx_count == rx_expect) rx_phase = PHC_SUM;
                end
                PHC_SUM: begin
                    if (r.data_byte == rx_xor) begin
                        rx_phase = PHC_END;
                    end else begin
                        rx_phase = PHC_START;
                        res.ev   = EV_SUM;
                    end
                end
                PHC_END: begin
                    if (r.data_byte == END_BYTE) begin
                        rx_acc_len = rx_count;
                        res.ev     = EV_OK;
                    end else begin
                        res.ev = EV_END;
                    end
                    rx_phase = PHC_START;
                end
                default: begin
                    if (r.data_byte == START_BYTE) begin
                        rx_count  = 8'h00;
                        rx_expect = 8'h00;
                        rx_xor    = 8'h00;
                        rx_phase  = PHC_LEN;
                    end else begin
                        rx_phase = PHC_START;
                    end
                end
            endcase
        end else if (r.read_index < rx_acc_len) begin
            res.rd = rx_store[r.read_index];
        end
        res.len = rx_acc_len;
        res.ph  = rx_phase;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("result %0d: %s got %0h, want %0h", res_count, field, got, want);
        err_count++;
    endtask

    task automatic queue_req(input logic req, input logic [7:0] data, input logic [7:0] idx,
                             input bit counted);
        rx_req_t r;
        r.req_type   = req;
        r.data_byte  = data;
        r.read_index = idx;
        pending_reqs.push_back(r);
        if (counted) stim_count++;
    endtask

    task automatic queue_read();
        logic [7:0] idx;
        idx = ($urandom_range(99) < 70) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
        queue_req(REQ_RD, 8'($urandom_range(255)), idx, 1'b1);
    endtask

    task automatic queue_frame(input int len, input frame_fault_t fault);
        logic [7:0] sum;
        logic [7:0] b;
        int         stop;
        sum  = 8'h00;
        stop = (fault == FR_CUT) ? $urandom_range(len) : len;
        queue_req(REQ_RX, START_BYTE, 8'($urandom_range(255)), 1'b1);
        queue_req(REQ_RX, 8'(len), 8'($urandom_range(255)), 1'b1);
        for (int i = 0; i < stop; i++) begin
            b   = 8'($urandom_range(255));
            sum = sum ^ b;
            queue_req(REQ_RX, b, 8'($urandom_range(255)), 1'b1);
            if ($urandom_range(99) < 8) queue_read();
        end
        if (fault == FR_CUT) return;
        if (fault == FR_BAD_SUM) sum = sum ^ (8'h01 << $urandom_range(7));
        queue_req(REQ_RX, sum, 8'($urandom_range(255)), 1'b1);
        b = END_BYTE;
        if (fault == FR_BAD_END) begin
            b = 8'($urandom_range(255));
            if (b == END_BYTE) b = 8'hFF;
        end
        queue_req(REQ_RX, b, 8'($urandom_range(255)), 1'b1);
    endtask

    task automatic queue_traffic(input int n);
        int           first;
        int           pick;
        int           len;
        logic [7:0]   b;
        frame_fault_t f;
        first = stim_count;
        while (stim_count - first < n) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                b = 8'($urandom_range(255));
                if (b == START_BYTE) b = 8'hA5;
                queue_req(REQ_RX, b, 8'($urandom_range(255)), 1'b0);
            end else if (pick < 25) begin
                queue_read();
            end else begin
                len  = ($urandom_range(99) < 90) ? $urandom_range(12) : $urandom_range(40, 13);
                pick = $urandom_range(99);
                if (pick < 70)      f = FR_GOOD;
                else if (pick < 80) f = FR_BAD_SUM;
                else if (pick < 90) f = FR_BAD_END;
                else                f = FR_CUT;
                queue_frame(len, f);
            end
        end
    endtask

    task automatic drain_reqs();
        while (pending_reqs.size() != 0) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        rx_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.req_type;
                s_tdata  <= {nxt.read_index, nxt.data_byte};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        frame_res_t want;
        rx_req_t    got_req;
        if (!aresetn) begin
            req_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_res.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[7:0], 8'h00);
                end else begin
                    want = expected_res.pop_front();
                    ev_tally[want.ev]++;
                    if (m_tdata[1:0] !== want.ev)
                        report_mismatch("event_res", 8'(m_tdata[1:0]), 8'(want.ev));
                    if (m_tdata[9:2] !== want.len)
                        report_mismatch("frame_length", m_tdata[9:2], want.len);
                    if (m_tdata[17:10] !== want.rd)
                        report_mismatch("read_data", m_tdata[17:10], want.rd);
                    if (m_tdata[20:18] !== want.ph)
                        report_mismatch("phase_now", 8'(m_tdata[20:18]), 8'(want.ph));
                    if (m_tdata[23:21] !== 3'b000)
                        report_mismatch("padding", 8'(m_tdata[23:21]), 8'h00);
                end
                res_count++;
            end
            req_taken <= s_tvalid && s_tready;
            if (s_tvalid && !s_tready) in_stalls++;
            if (s_tvalid && s_tready) begin
                got_req.req_type   = s_tuser;
                got_req.data_byte  = s_tdata[7:0];
                got_req.read_index = s_tdata[15:8];
                if (s_tuser == REQ_RX) rx_reqs++;
                else                   rd_reqs++;
                expected_res.push_back(frame_rx_predict(got_req));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 expected_res.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        queue_req(REQ_RD, 8'h00, 8'h00, 1'b1);
        queue_req(REQ_RD, 8'hFF, 8'hFF, 1'b1);
        queue_req(REQ_RX, 8'hFF, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h00, 8'hFF, 1'b1);
        queue_req(REQ_RX, START_BYTE, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h00, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h00, 8'h00, 1'b1);
        queue_req(REQ_RX, END_BYTE, 8'h00, 1'b1);
        queue_req(REQ_RX, START_BYTE, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h01, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'hFF, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h00, 8'h00, 1'b1);
        queue_req(REQ_RX, START_BYTE, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h02, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'hA5, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h5A, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'hFF, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h00, 8'h00, 1'b1);
        queue_req(REQ_RX, START_BYTE, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h03, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h02, 8'h00, 1'b1);
        queue_req(REQ_RD, 8'h00, 8'h01, 1'b1);
        queue_req(REQ_RX, 8'h03, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h80, 8'h00, 1'b1);
        queue_req(REQ_RX, 8'h81, 8'h00, 1'b1);
        queue_req(REQ_RX, END_BYTE, 8'h00, 1'b1);
        queue_req(REQ_RD, 8'h00, 8'h00, 1'b1);
        queue_req(REQ_RD, 8'h00, 8'h02, 1'b1);
        queue_req(REQ_RD, 8'h00, 8'h03, 1'b1);
        drain_reqs();

        queue_traffic(50);
        queue_frame(255, FR_GOOD);
        queue_req(REQ_RD, 8'h00, 8'h00, 1'b1);
        queue_req(REQ_RD, 8'h00, 8'hFE, 1'b1);
        queue_req(REQ_RD, 8'h00, 8'hFF, 1'b1);
        drain_reqs();

        send_idle_pct = 45;
        queue_traffic(50);
        drain_reqs();

        send_idle_pct = 0;
        rcv_stall_pct = 45;
        queue_traffic(50);
        drain_reqs();

        send_idle_pct = 8;
        rcv_stall_pct = 8;
        queue_traffic(50);
        drain_reqs();

        // hold the result side off while requests keep coming
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_go       = 1'b1;
        queue_traffic(40);
        drain_reqs();

        while (s_tvalid || expected_res.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests (%0d stream bytes, %0d reads), %0d results checked",
                 rx_reqs + rd_reqs, rx_reqs, rd_reqs, res_count);
        $display("frames accepted %0d, checksum drops %0d, bad end bytes %0d, stall cycles %0d",
                 ev_tally[EV_OK], ev_tally[EV_SUM], ev_tally[EV_END], in_stalls);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
